[hdl/vvfe_pkg.sv]
// Package for the voxel visible face extractor: command, side and face codes,
// sequencer states and grid size defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vvfe_pkg;

   localparam int DEF_GRID_WIDTH  = 16;
   localparam int DEF_GRID_HEIGHT = 256;
   localparam int DEF_GRID_DEPTH  = 16;

   localparam int FACE_COUNT = 6;

   localparam logic [1:0] CMD_CELL    = 2'd0;
   localparam logic [1:0] CMD_EDGE    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_EXAM    = 2'd3;

   localparam logic [1:0] SIDE_NX = 2'd0;
   localparam logic [1:0] SIDE_PX = 2'd1;
   localparam logic [1:0] SIDE_NZ = 2'd2;
   localparam logic [1:0] SIDE_PZ = 2'd3;

   localparam logic [2:0] FACE_FRONT  = 3'd0;
   localparam logic [2:0] FACE_BACK   = 3'd1;
   localparam logic [2:0] FACE_RIGHT  = 3'd2;
   localparam logic [2:0] FACE_LEFT   = 3'd3;
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXAM,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

[hdl/vvfe_ram.sv]
// Simple dual-port RAM: one write and one registered read per cycle.
// Generic storage used for the cell and edge stores; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vvfe_ram #(
   parameter int DW = 15,
   parameter int AW = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] wa,
   input  wire logic [DW-1:0] wd,
   input  wire logic          re,
   input  wire logic [AW-1:0] ra,
   output logic      [DW-1:0] rd
);

   logic [DW-1:0] mem [(1 << AW)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd <= mem[ra];
      end
   end

endmodule
`default_nettype wire

[hdl/voxel_visible_face_extractor_unit.sv]
// Voxel visible face extractor: cell and edge stores, examine sequencer, face emitter.
// Depends on vvfe_pkg and vvfe_ram.
//
//   channel | ports            | dir | payload
//   req     | req_t*           | in  | tuser=command, tdata=position/edge/active/material
//   rsp     | rsp_t*           | out | tuser=face, tlast=last face, tdata=cell/layer/vertex
//   csr     | csr_valid/ready  | in  | csr_data=neighbour_present
//
// Write and restart words act in the accepting cycle. An examine word has the accepting
// cycle, then eight steps: step 0 reads the center from the cell store, steps 1 to 6
// the six neighbours plus edge reads; then one visible face is emitted per cycle
// unless the output stalls, and an active cell that shows no face passes through the
// emit state. After reset a clearing pass over 2**max(cell, edge addr bits) addresses
// (65536 by default) runs before the first word is taken. A stalled result holds the
// emitter; the last face sits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none
module voxel_visible_face_extractor_unit
   import vvfe_pkg::*;
#(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int GRID_DEPTH  = DEF_GRID_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] pos_x, [11:4] pos_y, [15:12] pos_z, [17:16] edge_side, [18] active,
   // [32:19] material_id, [39:33] zero
   input  wire logic [39:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] cell_x, [11:4] cell_y, [15:12] cell_z, [31:16] layer,
   // [52:32] first_vertex, [55:53] zero
   output logic [55:0]      rsp_tdata,
   // [2:0] face
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data
);

   localparam int XW   = $clog2(GRID_WIDTH);
   localparam int YW   = $clog2(GRID_HEIGHT);
   localparam int ZW   = $clog2(GRID_DEPTH);
   localparam int SPAN = (GRID_WIDTH > GRID_DEPTH) ? GRID_WIDTH : GRID_DEPTH;
   localparam int CW   = $clog2(SPAN);
   localparam int CAW  = XW + YW + ZW;
   localparam int EAW  = 2 + YW + CW;
   localparam int CLW  = (CAW > EAW) ? CAW : EAW;
   localparam logic [XW-1:0] XMAX = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] YMAX = YW'(GRID_HEIGHT - 1);
   localparam logic [ZW-1:0] ZMAX = ZW'(GRID_DEPTH - 1);

   // input word fields
   logic [3:0]  in_x, in_z;
   logic [7:0]  in_y;
   logic [1:0]  in_side;
   logic        in_act;
   logic [13:0] in_mat;
   assign in_x    = req_tdata[3:0];
   assign in_y    = req_tdata[11:4];
   assign in_z    = req_tdata[15:12];
   assign in_side = req_tdata[17:16];
   assign in_act  = req_tdata[18];
   assign in_mat  = req_tdata[32:19];

   state_type   state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic [3:0]  np_ff, np_in;
   logic [20:0] vcount_ff, vcount_in;
   logic [3:0]  px_ff, px_in, pz_ff, pz_in;
   logic [7:0]  py_ff, py_in;
   logic        cen_ff, cen_in;
   logic [15:0] mbase_ff, mbase_in;
   logic [5:0]  show_ff, show_in;

   logic        ov_ff, ov_in;
   logic [2:0]  oface_ff, oface_in;
   logic [15:0] olayer_ff, olayer_in;
   logic [20:0] overt_ff, overt_in;
   logic        olast_ff, olast_in;
   logic [3:0]  ox_ff, ox_in, oz_ff, oz_in;
   logic [7:0]  oy_ff, oy_in;
   logic        out_load;

   logic           cell_we, cell_re, edge_we, edge_re;
   logic [CAW-1:0] cell_wa, cell_ra;
   logic [14:0]    cell_wd, cell_rd;
   logic [EAW-1:0] edge_wa, edge_ra;
   logic           edge_wd;
   logic [0:0]     edge_rd;

   vvfe_ram #(.DW(15), .AW(CAW)) u_cell_ram (
      .clock(clock), .we(cell_we), .wa(cell_wa), .wd(cell_wd),
      .re(cell_re), .ra(cell_ra), .rd(cell_rd)
   );

   vvfe_ram #(.DW(1), .AW(EAW)) u_edge_ram (
      .clock(clock), .we(edge_we), .wa(edge_wa), .wd(edge_wd),
      .re(edge_re), .ra(edge_ra), .rd(edge_rd)
   );

   logic [XW-1:0] xi;
   logic [YW-1:0] yi;
   logic [ZW-1:0] zi;
   assign xi = XW'(px_ff);
   assign yi = YW'(py_ff);
   assign zi = ZW'(pz_ff);

   assign csr_ready = 1'b1;

   always_comb begin
      logic [2:0]    fi, ef, pf;
      logic          bnd, sv;
      logic [5:0]    rest;
      logic [3:0]    ec;
      state_in  = state_ff;
      step_in   = step_ff;
      clr_in    = clr_ff;
      np_in     = (csr_valid && csr_ready) ? csr_data : np_ff;
      vcount_in = vcount_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      cen_in    = cen_ff;
      mbase_in  = mbase_ff;
      show_in   = show_ff;
      ov_in     = ov_ff && !rsp_tready;
      oface_in  = oface_ff;
      olayer_in = olayer_ff;
      overt_in  = overt_ff;
      olast_in  = olast_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      oz_in     = oz_ff;
      out_load  = 1'b0;
      req_tready = 1'b0;
      cell_we = 1'b0;
      cell_wa = '0;
      cell_wd = '0;
      cell_re = 1'b0;
      cell_ra = '0;
      edge_we = 1'b0;
      edge_wa = '0;
      edge_wd = 1'b0;
      edge_re = 1'b0;
      edge_ra = '0;
      fi   = step_ff - 3'd1;
      ef   = step_ff - 3'd2;
      pf   = '0;
      bnd  = 1'b0;
      sv   = 1'b0;
      rest = '0;
      ec   = (in_side == SIDE_NX || in_side == SIDE_PX) ? in_z : in_x;

      case (state_ff)
         ST_CLEAR: begin
            cell_we = 1'b1;
            cell_wa = clr_ff[CAW-1:0];
            edge_we = 1'b1;
            edge_wa = clr_ff[EAW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               px_in = in_x;
               py_in = in_y;
               pz_in = in_z;
               case (req_tuser)
                  CMD_CELL: begin
                     if (32'(in_x) < GRID_WIDTH && 32'(in_y) < GRID_HEIGHT &&
                         32'(in_z) < GRID_DEPTH) begin
                        cell_we = 1'b1;
                        cell_wa = {ZW'(in_z), YW'(in_y), XW'(in_x)};
                        cell_wd = {in_act, in_mat};
                     end
                  end
                  CMD_EDGE: begin
                     if (32'(in_y) < GRID_HEIGHT &&
                         32'(ec) < ((in_side == SIDE_NX || in_side == SIDE_PX) ?
                                    GRID_DEPTH : GRID_WIDTH)) begin
                        edge_we = 1'b1;
                        edge_wa = {in_side, YW'(in_y), CW'(ec)};
                        edge_wd = in_act;
                     end
                  end
                  CMD_RESTART: begin
                     vcount_in = '0;
                  end
                  CMD_EXAM: begin
                     if (32'(in_x) < GRID_WIDTH && 32'(in_y) < GRID_HEIGHT &&
                         32'(in_z) < GRID_DEPTH) begin
                        step_in  = '0;
                        show_in  = '0;
                        state_in = ST_EXAM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXAM: begin
            // issue: step 0 reads the center, step f+1 the neighbour of face f
            if (step_ff == 3'd0) begin
               cell_re = 1'b1;
               cell_ra = {zi, yi, xi};
            end else if (step_ff <= 3'd6) begin
               cell_re = 1'b1;
               edge_re = 1'b1;
               case (fi)
                  FACE_FRONT: begin
                     cell_ra = {zi + 1'b1, yi, xi};
                     edge_ra = {SIDE_PZ, yi, CW'(px_ff)};
                  end
                  FACE_BACK: begin
                     cell_ra = {zi - 1'b1, yi, xi};
                     edge_ra = {SIDE_NZ, yi, CW'(px_ff)};
                  end
                  FACE_RIGHT: begin
                     cell_ra = {zi, yi, xi + 1'b1};
                     edge_ra = {SIDE_PX, yi, CW'(pz_ff)};
                  end
                  FACE_LEFT: begin
                     cell_ra = {zi, yi, xi - 1'b1};
                     edge_ra = {SIDE_NX, yi, CW'(pz_ff)};
                  end
                  FACE_TOP:    cell_ra = {zi, yi + 1'b1, xi};
                  FACE_BOTTOM: cell_ra = {zi, yi - 1'b1, xi};
                  default: begin
                  end
               endcase
            end
            // evaluate the word read one step earlier
            if (step_ff == 3'd1) begin
               cen_in   = cell_rd[14];
               mbase_in = 16'({cell_rd[13:0], 2'b00}) + 16'({cell_rd[13:0], 1'b0});
            end else if (step_ff >= 3'd2) begin
               case (ef)
                  FACE_FRONT: begin
                     bnd = (zi == ZMAX);
                     sv  = bnd ? !(np_ff[SIDE_PZ] && edge_rd[0]) : !cell_rd[14];
                  end
                  FACE_BACK: begin
                     bnd = (zi == '0);
                     sv  = bnd ? !(np_ff[SIDE_NZ] && edge_rd[0]) : !cell_rd[14];
                  end
                  FACE_RIGHT: begin
                     bnd = (xi == XMAX);
                     sv  = bnd ? !(np_ff[SIDE_PX] && edge_rd[0]) : !cell_rd[14];
                  end
                  FACE_LEFT: begin
                     bnd = (xi == '0);
                     sv  = bnd ? !(np_ff[SIDE_NX] && edge_rd[0]) : !cell_rd[14];
                  end
                  FACE_TOP: begin
                     bnd = (yi == YMAX);
                     sv  = bnd || !cell_rd[14];
                  end
                  FACE_BOTTOM: begin
                     bnd = (yi == '0);
                     sv  = bnd || !cell_rd[14];
                  end
                  default: begin
                  end
               endcase
               show_in[ef] = sv;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = cen_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (show_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!ov_ff || rsp_tready) begin
               for (int i = FACE_COUNT - 1; i >= 0; i--) begin
                  if (show_ff[i]) begin
                     pf = 3'(i);
                  end
               end
               rest         = show_ff;
               rest[pf]     = 1'b0;
               out_load     = 1'b1;
               ov_in        = 1'b1;
               oface_in     = pf;
               olayer_in    = mbase_ff + 16'(pf);
               overt_in     = vcount_ff;
               olast_in     = (rest == '0);
               ox_in        = px_ff;
               oy_in        = py_ff;
               oz_in        = pz_ff;
               vcount_in    = vcount_ff + 21'd4;
               show_in      = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         step_ff   <= '0;
         clr_ff    <= '0;
         np_ff     <= '0;
         vcount_ff <= '0;
         ov_ff     <= 1'b0;
         cen_ff    <= 1'b0;
         show_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         clr_ff    <= clr_in;
         np_ff     <= np_in;
         vcount_ff <= vcount_in;
         ov_ff     <= ov_in;
         cen_ff    <= cen_in;
         show_ff   <= show_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      mbase_ff  <= mbase_in;
      oface_ff  <= oface_in;
      olayer_ff <= olayer_in;
      overt_ff  <= overt_in;
      olast_ff  <= olast_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oz_ff     <= oz_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = oface_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {3'b000, overt_ff, olayer_ff, oz_ff, oy_ff, ox_ff};

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_tvalid)
      else $error("result shown during clearing pass");

   a_idle_only_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("input taken while busy");

   a_vertex_step: assert property (@(posedge clock) disable iff (reset)
      out_load |=> vcount_ff == $past(vcount_ff) + 21'd4)
      else $error("vertex count did not advance by one face");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_load |-> show_ff != '0 && cen_ff)
      else $error("face emitted without a visible face pending");

endmodule
`default_nettype wire

[verif/voxel_visible_face_extractor_unit_test.sv]
// Testbench for voxel_visible_face_extractor_unit. It predicts the face words of
// every examine command from its own copy of the cell and edge stores.
// Depends on vvfe_pkg and the unit RTL.
`timescale 1ns / 1ps
module voxel_visible_face_extractor_unit_test;
   import vvfe_pkg::*;

   typedef struct {
      logic [1:0]  cmd;
      logic [3:0]  x;
      logic [7:0]  y;
      logic [3:0]  z;
      logic [1:0]  side;
      logic        act;
      logic [13:0] mat;
   } voxel_cmd_t;

   typedef struct {
      logic [2:0]  face;
      logic [3:0]  x;
      logic [7:0]  y;
      logic [3:0]  z;
      logic [15:0] layer;
      logic [20:0] vtx;
      logic        last;
   } face_word_t;

   localparam int STALL_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = CMD_CELL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_data = '0;

   voxel_cmd_t pending_cmds[$];
   voxel_cmd_t held_cmd;
   face_word_t faces_due[$];

   // predictor state
   logic [14:0] cell_mem [65536];
   bit          edge_mem [16384];
   logic [20:0] vtx_count;
   logic [3:0]  nbr_present;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   voxel_visible_face_extractor_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void queue_cmd(voxel_cmd_t w);
      pending_cmds = {pending_cmds, w};
   endfunction

   function automatic bit cell_solid(int x, int y, int z);
      return cell_mem[x + y * 16 + z * 4096][14];
   endfunction

   // absent neighbour chunk reads as empty
   function automatic bit plane_solid(int side, int y, int c);
      if (!nbr_present[side]) return 0;
      return edge_mem[(side * 256 + y) * 16 + c];
   endfunction

   function automatic void predict_faces(voxel_cmd_t w);
      bit show [6];
      logic [14:0] cur_word;
      face_word_t fw;
      int idx;
      int last_idx;
      idx = faces_due.size();
      last_idx = -1;
      case (w.cmd)
         CMD_CELL: cell_mem[w.x + w.y * 16 + w.z * 4096] = {w.act, w.mat};
         CMD_EDGE: edge_mem[(w.side * 256 + w.y) * 16 +
                            ((w.side < 2) ? w.z : w.x)] = w.act;
         CMD_RESTART: vtx_count = '0;
         CMD_EXAM: begin
            cur_word = cell_mem[w.x + w.y * 16 + w.z * 4096];
            if (cur_word[14]) begin
               show[FACE_FRONT] = (w.z == 15) ? !plane_solid(SIDE_PZ, w.y, w.x)
                                              : !cell_solid(w.x, w.y, w.z + 1);
               show[FACE_BACK] = (w.z == 0) ? !plane_solid(SIDE_NZ, w.y, w.x)
                                            : !cell_solid(w.x, w.y, w.z - 1);
               show[FACE_RIGHT] = (w.x == 15) ? !plane_solid(SIDE_PX, w.y, w.z)
                                              : !cell_solid(w.x + 1, w.y, w.z);
               show[FACE_LEFT] = (w.x == 0) ? !plane_solid(SIDE_NX, w.y, w.z)
                                            : !cell_solid(w.x - 1, w.y, w.z);
               show[FACE_TOP] = (w.y == 255) || !cell_solid(w.x, w.y + 1, w.z);
               show[FACE_BOTTOM] = (w.y == 0) || !cell_solid(w.x, w.y - 1, w.z);
               for (int f = 0; f < FACE_COUNT; f++) begin
                  if (show[f]) begin
                     fw.face = f[2:0];
                     fw.x = w.x;
                     fw.y = w.y;
                     fw.z = w.z;
                     fw.layer = 16'(cur_word[13:0] * 6 + f);
                     fw.vtx = vtx_count;
                     fw.last = 1'b0;
                     vtx_count = vtx_count + 21'd4;
                     faces_due = {faces_due, fw};
                     last_idx = faces_due.size() - 1;
                  end
               end
               if (last_idx >= idx) faces_due[last_idx].last = 1'b1;
            end
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_faces(held_cmd);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_cmds.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            held_cmd = pending_cmds.pop_front();
            req_tuser <= held_cmd.cmd;
            req_tdata <= {7'b0, held_cmd.mat, held_cmd.act, held_cmd.side,
                          held_cmd.z, held_cmd.y, held_cmd.x};
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
   end

   // monitor and checker
   always @(posedge clock) begin
      face_word_t exp_w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (faces_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected face word tdata=%h tuser=%0d", rsp_tdata, rsp_tuser);
            end else begin
               exp_w = faces_due.pop_front();
               if (rsp_tuser !== exp_w.face || rsp_tdata[3:0] !== exp_w.x ||
                   rsp_tdata[11:4] !== exp_w.y || rsp_tdata[15:12] !== exp_w.z ||
                   rsp_tdata[31:16] !== exp_w.layer || rsp_tdata[52:32] !== exp_w.vtx ||
                   rsp_tlast !== exp_w.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp face=%0d xyz=%0d,%0d,%0d layer=%0d vtx=%0d last=%0d",
                              exp_w.face, exp_w.x, exp_w.y, exp_w.z, exp_w.layer,
                              exp_w.vtx, exp_w.last,
                              "; got face=%0d xyz=%0d,%0d,%0d layer=%0d vtx=%0d last=%0d",
                              rsp_tuser, rsp_tdata[3:0], rsp_tdata[11:4], rsp_tdata[15:12],
                              rsp_tdata[31:16], rsp_tdata[52:32], rsp_tlast);
               end
            end
         end
         // long hold-off lets the block back up into its input
         if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || hold_left > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pick_coord(int top);
      int r;
      r = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return r;
         4, 5, 6:    return top - r;
         default:    return $urandom_range(0, top);
      endcase
   endfunction

   function automatic voxel_cmd_t make_cmd(logic [1:0] cmd, int x, int y, int z,
                                           int side, bit act, int mat);
      voxel_cmd_t w;
      w.cmd = cmd;
      w.x = x[3:0];
      w.y = y[7:0];
      w.z = z[3:0];
      w.side = side[1:0];
      w.act = act;
      w.mat = mat[13:0];
      return w;
   endfunction

   function automatic voxel_cmd_t random_cmd();
      int pick;
      int mat;
      pick = $urandom_range(0, 99);
      mat = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 16383)
                                          : $urandom_range(0, 10921);
      return make_cmd((pick < 40) ? CMD_CELL : (pick < 55) ? CMD_EDGE :
                      (pick < 59) ? CMD_RESTART : CMD_EXAM,
                      pick_coord(15), pick_coord(255), pick_coord(15),
                      $urandom_range(0, 3), $urandom_range(0, 5) != 0, mat);
   endfunction

   task automatic wait_drained();
      @(posedge clock);
      while (pending_cmds.size() > 0 || req_tvalid || faces_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_neighbours(logic [3:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      nbr_present = v;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count, int s_pct, int r_pct, bit with_hold);
      send_idle_pct <= s_pct;
      recv_idle_pct <= r_pct;
      for (int i = 0; i < count; i++) queue_cmd(random_cmd());
      if (with_hold) hold_request <= 1'b1;
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 65536; i++) cell_mem[i] = '0;
      for (int i = 0; i < 16384; i++) edge_mem[i] = 0;
      vtx_count = '0;
      nbr_present = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_neighbours(4'h0);
      // lone cell: all six faces; grid corners; material overflow of layer
      queue_cmd(make_cmd(CMD_CELL, 0, 0, 0, 0, 1, 0));
      queue_cmd(make_cmd(CMD_EXAM, 0, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_CELL, 15, 255, 15, 3, 1, 16383));
      queue_cmd(make_cmd(CMD_EXAM, 15, 255, 15, 0, 0, 0));
      queue_cmd(make_cmd(CMD_CELL, 1, 0, 0, 0, 1, 10921));
      queue_cmd(make_cmd(CMD_CELL, 0, 1, 0, 0, 1, 5));
      queue_cmd(make_cmd(CMD_EXAM, 0, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_EXAM, 1, 0, 0, 0, 0, 0));
      // edge bits set but neighbours absent: faces still show
      for (int s = 0; s < 4; s++)
         queue_cmd(make_cmd(CMD_EDGE, 0, 0, 0, s, 1, 0));
      queue_cmd(make_cmd(CMD_EDGE, 15, 255, 15, SIDE_PZ, 1, 0));
      queue_cmd(make_cmd(CMD_EXAM, 0, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_RESTART, 0, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_EXAM, 15, 255, 15, 0, 0, 0));
      // inactive cell gives nothing
      queue_cmd(make_cmd(CMD_CELL, 1, 0, 0, 0, 0, 10921));
      queue_cmd(make_cmd(CMD_EXAM, 1, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_EXAM, 7, 100, 9, 0, 0, 0));
      wait_drained();

      write_neighbours(4'hF);
      queue_cmd(make_cmd(CMD_EXAM, 0, 0, 0, 0, 0, 0));
      queue_cmd(make_cmd(CMD_EXAM, 15, 255, 15, 0, 0, 0));
      wait_drained();

      run_random(145, 38, 83, 0);
      write_neighbours(4'($urandom_range(1, 14)));
      run_random(145, 83, 38, 0);
      write_neighbours(4'($urandom_range(0, 15)));
      run_random(60, 0, 0, 1);
      write_neighbours(4'h0);
      run_random(80, 0, 0, 0);

      if (faces_due.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
hdl/vvfe_pkg.sv
hdl/vvfe_ram.sv
hdl/voxel_visible_face_extractor_unit.sv
verif/voxel_visible_face_extractor_unit_test.sv
